@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DVRS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DVRS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dvrs_pkg.sv @@
`timescale 1ns / 1ps
package dvrs_pkg;

  // Opcodes carried in s_axis_tuser
  localparam logic [1:0] OP_SET   = 2'd0;
  localparam logic [1:0] OP_RUN   = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Result kinds carried in m_axis_tuser
  localparam logic KIND_RUN   = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Register indexes (byte address = 4 * index)
  localparam logic [1:0] REG_ACTIVE  = 2'd0;
  localparam logic [1:0] REG_ROUNDS  = 2'd1;
  localparam logic [1:0] REG_CEILING = 2'd2;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic [4:0]  ACTIVE_RST  = 5'd16;
  localparam logic [7:0]  ROUNDS_RST  = 8'd64;
  localparam logic [15:0] CEILING_RST = 16'hFFFF;

  // Control into the relax unit
  typedef struct packed {
    logic direct;  // neighbor is the destination itself
    logic skip;    // no candidate this cycle
  } relax_ctl_t;

endpackage

@@ rtl/dvrs_relax.sv @@
`timescale 1ns / 1ps
module dvrs_relax
  import dvrs_pkg::*;
#(
  parameter int CW = 17
) (
  input  logic [CW-1:0] lk_i,
  input  logic [CW-1:0] pv_i,
  input  logic [CW-1:0] best_i,
  input  logic [CW-1:0] ceil_i,
  input  relax_ctl_t    ctl_i,
  output logic          take_o,
  output logic [CW-1:0] cand_o
);

  logic [CW-1:0] addend;

  // Both terms are below 2^(CW-1) when used, so the sum fits CW bits.
  assign addend = ctl_i.direct ? '0 : pv_i;
  assign cand_o = lk_i + addend;

  assign take_o = !ctl_i.skip && !lk_i[CW-1] && (ctl_i.direct || !pv_i[CW-1]) &&
                  (cand_o < ceil_i) && (cand_o < best_i);

endmodule

@@ rtl/distance_vector_route_solver_unit.sv @@
`timescale 1ns / 1ps
// Channel   | Dir | Fields                                                  | Handshake
// s_axis    | in  | tuser: opcode; tdata: first, second, link_cost, down    | tvalid/tready
// m_axis    | out | tuser: result_kind; tdata: rounds, conv, reach, hop, cost | tvalid/tready
// apb       | in  | active_routers @0x0, round_limit @0x4, cost_ceiling @0x8 | pready tied high
//
// Reset: after rst_ni releases, a pass over all 2^(2*ceil(log2 MAX_ROUTERS)) addresses
//   (256 by default) resets link, best-cost and next-hop memories; s_axis_tready stays low.
// Set: two symmetric link writes (S_SET1, S_SET2); query: a best-cost read (S_QRY).
// Run: per round one copy sweep of the best-cost memory, then each of the n*(n-1) router
//   pairs in turn through the single add/compare unit (S_PAIR, S_PAIRW, S_SCAN, S_WRITE),
//   then index stepping and the round end (S_REND).
// One transaction at a time; a result waits in the output register while m_axis_tready is
//   low, the next input is taken meanwhile, and a later result holds in S_OUT until then.
module distance_vector_route_solver_unit
  import dvrs_pkg::*;
#(
  parameter int MAX_ROUTERS = 16,
  parameter int COST_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // s_axis_tdata: [3:0] first_router, [7:4] second_router, [23:8] link_cost, [24] link_down
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // s_axis_tuser: [1:0] opcode
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // m_axis_tdata: [7:0] rounds_taken, [8] converged_flag, [9] reachable,
  //               [13:10] next_hop, [29:14] route_cost
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // m_axis_tuser: [0] result_kind
  output logic                  m_axis_tuser,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  localparam int CW    = COST_BITS + 1;            // cost plus unreachable bit
  localparam int RW    = $clog2(MAX_ROUTERS);      // router index
  localparam int NW    = $clog2(MAX_ROUTERS + 1);  // router count
  localparam int AW2   = 2 * RW;                   // table address
  localparam int DEPTH = 1 << AW2;
  localparam int KW    = AW2 + 1;
  localparam int AW    = (NW > 5) ? NW : 5;
  localparam int WW    = (CW > 16) ? CW : 16;
  localparam int LB    = (COST_BITS < 16) ? COST_BITS : 16;
  localparam logic [CW-1:0] UNREACH = {1'b1, {COST_BITS{1'b0}}};

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_SET1, S_SET2, S_QRY, S_COPY,
    S_PAIR, S_PAIRW, S_SCAN, S_WRITE, S_REND, S_OUT
  } state_e;

  state_e state_q;

  // ---------------- configuration registers ----------------
  logic [4:0]  act_q;
  logic [7:0]  lim_q;
  logic [15:0] ceil_q;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q  <= ACTIVE_RST;
      lim_q  <= ROUNDS_RST;
      ceil_q <= CEILING_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_ACTIVE:  act_q  <= pwdata[4:0];
        REG_ROUNDS:  lim_q  <= pwdata[7:0];
        REG_CEILING: ceil_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ACTIVE:  prdata = PDATA_W'(act_q);
      REG_ROUNDS:  prdata = PDATA_W'(lim_q);
      REG_CEILING: prdata = PDATA_W'(ceil_q);
      default:     prdata = '0;
    endcase
  end

  // ---------------- derived settings ----------------
  logic [NW-1:0] n_w;
  logic [7:0]    lim_w;
  logic [WW-1:0] ceil_w;
  logic [CW-1:0] ceil_eff;

  assign n_w    = (AW'(act_q) > AW'(MAX_ROUTERS)) ? NW'(MAX_ROUTERS) : NW'(act_q);
  assign lim_w  = (lim_q == 8'd0) ? 8'd1 : lim_q;
  assign ceil_w = WW'(ceil_q);
  assign ceil_eff = (ceil_w >= WW'(UNREACH)) ? UNREACH : CW'(ceil_w);

  // ---------------- input decode ----------------
  logic [1:0]    in_op;
  logic [3:0]    in_first;
  logic [3:0]    in_second;
  logic [15:0]   in_cost;
  logic          in_down;
  logic          in_acc;
  logic          a_ok;
  logic          b_ok;
  logic [CW-1:0] cost_in;

  assign in_op     = s_axis_tuser;
  assign in_first  = s_axis_tdata[3:0];
  assign in_second = s_axis_tdata[7:4];
  assign in_cost   = s_axis_tdata[23:8];
  assign in_down   = s_axis_tdata[24];
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign a_ok      = AW'(in_first) < AW'(n_w);
  assign b_ok      = AW'(in_second) < AW'(n_w);

  always_comb begin
    cost_in = '0;
    cost_in[LB-1:0] = in_cost[LB-1:0];
  end

  // ---------------- sequencer registers ----------------
  logic [KW-1:0] k_q;
  logic          cp_vld_q;
  logic [AW2-1:0] cp_addr_q;
  logic [NW-1:0] r_q, d_q, v_q;
  logic [RW-1:0] pv_q;
  logic          pvld_q;
  logic [CW-1:0] best_q, old_q;
  logic [RW-1:0] hop_q;
  logic          stable_q;
  logic [7:0]    rnd_q;
  logic [RW-1:0] a_q, b_q;
  logic [CW-1:0] lval_q;

  logic          res_kind_q;
  logic [7:0]    res_rounds_q;
  logic          res_conv_q;
  logic          res_reach_q;
  logic [3:0]    res_hop_q;
  logic [15:0]   res_cost_q;

  logic                  m_valid_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                  m_user_q;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // ---------------- memories ----------------
  logic [CW-1:0] link_mem [DEPTH];
  logic [CW-1:0] best_mem [DEPTH];
  logic [RW-1:0] next_mem [DEPTH];
  logic [CW-1:0] prev_mem [DEPTH];

  logic           link_we, best_we;
  logic [AW2-1:0] link_wa, best_wa, link_ra, best_ra, prev_ra;
  logic [CW-1:0]  link_wd, best_wd;
  logic [RW-1:0]  next_wd;
  logic [CW-1:0]  link_rd_q, best_rd_q, prev_rd_q;
  logic [RW-1:0]  next_rd_q;

  always_comb begin
    link_we = 1'b0;
    link_wa = {a_q, b_q};
    link_wd = lval_q;
    best_we = 1'b0;
    best_wa = {r_q[RW-1:0], d_q[RW-1:0]};
    best_wd = best_q;
    next_wd = hop_q;
    case (state_q)
      S_CLEAR: begin
        link_we = 1'b1;
        link_wa = k_q[AW2-1:0];
        link_wd = UNREACH;
        best_we = 1'b1;
        best_wa = k_q[AW2-1:0];
        best_wd = UNREACH;
        next_wd = '0;
      end
      S_SET1:  link_we = 1'b1;
      S_SET2: begin
        link_we = 1'b1;
        link_wa = {b_q, a_q};
      end
      S_WRITE: best_we = 1'b1;
      default: ;
    endcase
  end

  assign link_ra = {r_q[RW-1:0], v_q[RW-1:0]};
  assign prev_ra = (state_q == S_PAIR) ? {r_q[RW-1:0], d_q[RW-1:0]}
                                       : {v_q[RW-1:0], d_q[RW-1:0]};
  assign best_ra = (state_q == S_COPY) ? k_q[AW2-1:0]
                                       : {RW'(in_first), RW'(in_second)};

  always_ff @(posedge clk_i) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    link_rd_q <= link_mem[link_ra];
  end

  always_ff @(posedge clk_i) begin
    if (best_we) begin
      best_mem[best_wa] <= best_wd;
      next_mem[best_wa] <= next_wd;
    end
    best_rd_q <= best_mem[best_ra];
    next_rd_q <= next_mem[best_ra];
  end

  // previous-round copy: written from the registered best-cost read, with the address delayed to match
  always_ff @(posedge clk_i) begin
    if (cp_vld_q) prev_mem[cp_addr_q] <= best_rd_q;
    prev_rd_q <= prev_mem[prev_ra];
  end

  // ---------------- shared add/compare unit ----------------
  relax_ctl_t    rctl;
  logic          take;
  logic [CW-1:0] cand;

  assign rctl.direct = (pv_q == d_q[RW-1:0]);
  assign rctl.skip   = !pvld_q || (pv_q == r_q[RW-1:0]);

  dvrs_relax #(
    .CW (CW)
  ) u_relax (
    .lk_i   (link_rd_q),
    .pv_i   (prev_rd_q),
    .best_i (best_q),
    .ceil_i (ceil_eff),
    .ctl_i  (rctl),
    .take_o (take),
    .cand_o (cand)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      k_q          <= '0;
      cp_vld_q     <= 1'b0;
      cp_addr_q    <= '0;
      r_q          <= '0;
      d_q          <= '0;
      v_q          <= '0;
      pv_q         <= '0;
      pvld_q       <= 1'b0;
      best_q       <= UNREACH;
      old_q        <= UNREACH;
      hop_q        <= '0;
      stable_q     <= 1'b1;
      rnd_q        <= '0;
      a_q          <= '0;
      b_q          <= '0;
      lval_q       <= UNREACH;
      res_kind_q   <= KIND_RUN;
      res_rounds_q <= '0;
      res_conv_q   <= 1'b0;
      res_reach_q  <= 1'b0;
      res_hop_q    <= '0;
      res_cost_q   <= '0;
      m_valid_q    <= 1'b0;
      m_data_q     <= '0;
      m_user_q     <= KIND_RUN;
    end else begin
      // S_OUT reloads the output register itself
      if (m_valid_q && m_axis_tready && state_q != S_OUT) m_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          k_q <= k_q + KW'(1);
          if (k_q == KW'(DEPTH - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_acc) begin
            a_q     <= RW'(in_first);
            b_q     <= RW'(in_second);
            lval_q  <= in_down ? UNREACH : cost_in;
            case (in_op)
              OP_SET: begin
                if (in_first != in_second && a_ok && b_ok) state_q <= S_SET1;
              end
              OP_RUN: begin
                rnd_q   <= 8'd1;
                k_q     <= '0;
                state_q <= S_COPY;
              end
              OP_QUERY: begin
                res_kind_q   <= KIND_QUERY;
                res_rounds_q <= '0;
                res_conv_q   <= 1'b0;
                if (a_ok && b_ok && in_first != in_second) begin
                  state_q <= S_QRY;
                end else begin
                  res_reach_q <= a_ok && b_ok;
                  res_hop_q   <= (a_ok && b_ok) ? in_first : 4'd0;
                  res_cost_q  <= '0;
                  state_q     <= S_OUT;
                end
              end
              default: ;
            endcase
          end
        end
        S_SET1: state_q <= S_SET2;
        S_SET2: state_q <= S_IDLE;
        S_QRY: begin
          res_reach_q <= !best_rd_q[CW-1];
          res_hop_q   <= best_rd_q[CW-1] ? 4'd0 : 4'(next_rd_q);
          res_cost_q  <= best_rd_q[CW-1] ? 16'd0 : 16'(best_rd_q[CW-2:0]);
          state_q     <= S_OUT;
        end
        S_COPY: begin
          cp_addr_q <= k_q[AW2-1:0];
          if (k_q < KW'(DEPTH)) begin
            cp_vld_q <= 1'b1;
            k_q      <= k_q + KW'(1);
          end else begin
            cp_vld_q <= 1'b0;
            r_q      <= '0;
            d_q      <= '0;
            stable_q <= 1'b1;
            state_q  <= S_PAIR;
          end
        end
        S_PAIR: begin
          if (r_q == n_w) begin
            state_q <= S_REND;
          end else if (d_q == n_w) begin
            d_q <= '0;
            r_q <= r_q + NW'(1);
          end else if (r_q == d_q) begin
            d_q <= d_q + NW'(1);
          end else begin
            state_q <= S_PAIRW;
          end
        end
        S_PAIRW: begin
          old_q   <= prev_rd_q;
          best_q  <= UNREACH;
          hop_q   <= '0;
          v_q     <= '0;
          pvld_q  <= 1'b0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          if (take) begin
            best_q <= cand;
            hop_q  <= pv_q;
          end
          if (v_q < n_w) begin
            pv_q   <= v_q[RW-1:0];
            pvld_q <= 1'b1;
            v_q    <= v_q + NW'(1);
          end else begin
            pvld_q <= 1'b0;
            if (!pvld_q) state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (best_q != old_q) stable_q <= 1'b0;
          d_q     <= d_q + NW'(1);
          state_q <= S_PAIR;
        end
        S_REND: begin
          res_kind_q   <= KIND_RUN;
          res_rounds_q <= rnd_q;
          res_reach_q  <= 1'b0;
          res_hop_q    <= '0;
          res_cost_q   <= '0;
          if (stable_q) begin
            res_conv_q <= 1'b1;
            state_q    <= S_OUT;
          end else if (rnd_q == lim_w) begin
            res_conv_q <= 1'b0;
            state_q    <= S_OUT;
          end else begin
            rnd_q   <= rnd_q + 8'd1;
            k_q     <= '0;
            state_q <= S_COPY;
          end
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_user_q  <= res_kind_q;
            m_data_q  <= {2'b00, res_cost_q, res_hop_q, res_reach_q, res_conv_q,
                          res_rounds_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/dvrs_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dvrs_checker
  import dvrs_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  s_axis_tvalid,
  input logic                  s_axis_tready,
  input logic [IN_DATA_W-1:0]  s_axis_tdata,
  input logic [1:0]            s_axis_tuser,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tuser
);

  `DVRS_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
  `DVRS_ASSERT_IMP(a_run_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == KIND_RUN, m_axis_tdata[31:9] == 23'd0, "run report carries query fields")
  `DVRS_ASSERT_IMP(a_qry_clean, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser == KIND_QUERY, m_axis_tdata[8:0] == 9'd0, "query answer carries run fields")
  `DVRS_ASSERT_NXT(a_busy, clk_i, rst_ni, s_axis_tvalid && s_axis_tready && (s_axis_tuser == OP_RUN || s_axis_tuser == OP_QUERY), !s_axis_tready, "ready while run or query in progress")

endmodule

bind distance_vector_route_solver_unit dvrs_checker u_dvrs_checker (.*);
